// ----- design/bbtf_pkg.sv -----
package bbtf_pkg;

  // fixed widths of the register and output fields
  localparam int THR_W      = 5;
  localparam int DIM_W      = 11;
  localparam int COORD_W    = 10;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // output buffer depth
  localparam int OUT_DEPTH = 4;

  // register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  // register reset values
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 5'd13;
  localparam logic [DIM_W-1:0] WIDTH_RESET     = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET    = 11'd480;

  // one result item, pixel_out in the lowest bit
  typedef struct packed {
    logic               frame_last;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] center_x;
    logic               pixel_out;
  } result_t;

  // per-pixel info carried down the pipeline
  typedef struct packed {
    logic               px;
    logic               first;
    logic               interior;
    logic               last;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } meta_t;

endpackage

// ----- design/bbtf_line_store.sv -----
module bbtf_line_store #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 4,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // one read and one write port, read returns the old contents
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ----- design/bbtf_col_cell.sv -----
module bbtf_col_cell #(
  parameter int W = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         clr,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  // holds one column sum and hands it on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (en) begin
      q <= clr ? '0 : d;
    end
  end

endmodule

// ----- design/bbtf_out_fifo.sv -----
module bbtf_out_fifo (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  bbtf_pkg::result_t                     push_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output bbtf_pkg::result_t                     out_data,
  output logic [$clog2(bbtf_pkg::OUT_DEPTH+1)-1:0] count
);
  import bbtf_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  result_t       buf_q [OUT_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          pop;

  assign out_valid = (count != '0);
  assign out_data  = buf_q[rd_ptr];
  assign pop       = out_valid & out_ready;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/binary_box_threshold_filter.sv -----
// Binary box threshold filter. Takes one binary pixel per item in raster order on the
// s_t* stream and sustains one item per clock while s_tready is high. For every pixel
// whose full (2*RADIUS_Y+1) x (2*RADIUS_X+1) window lies inside the frame it gives one
// result on the m_t* stream: 1 when the number of set pixels in the window is at least
// count_threshold, together with the centre coordinates; tlast marks the last interior
// pixel of a frame. Border pixels give no result. A result passes through the line store
// read, the column sum and window update, then the threshold compare into a four-item
// output buffer; s_tready drops only when that buffer has no room for the pixels still
// in flight. The line store is one memory read and written once per pixel, and a row of
// column cells shifts the recent column sums. line_width and frame_height of zero act as
// one and values above MAX_WIDTH/MAX_HEIGHT act as those maxima; write the registers
// only while no pixel is in flight.
module binary_box_threshold_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int RADIUS_Y   = 2,
  parameter int RADIUS_X   = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [0] pixel_in
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // [0] pixel_out, [10:1] center_x,
                                                     // [20:11] center_y
  output logic                            m_tlast,   // frame_last
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bbtf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bbtf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bbtf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bbtf_pkg::*;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int SB     = 2 * RADIUS_Y;
  localparam int NC     = 2 * RADIUS_X + 1;
  localparam int CSW    = $clog2(SB + 2);
  localparam int WW     = $clog2((SB + 1) * NC + 1);
  localparam int CMPW   = (WW > THR_W) ? WW : THR_W;
  localparam int WCW    = (DIM_W > XW + 1) ? DIM_W : XW + 1;
  localparam int HCW    = (DIM_W > YW + 1) ? DIM_W : YW + 1;
  localparam int FCW    = $clog2(OUT_DEPTH + 1);

  // registers
  logic [THR_W-1:0] count_threshold;
  logic [DIM_W-1:0] line_width;
  logic [DIM_W-1:0] frame_height;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_threshold <= THRESHOLD_RESET;
      line_width      <= WIDTH_RESET;
      frame_height    <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_THRESHOLD: count_threshold <= pwdata[THR_W-1:0];
        REG_WIDTH:     line_width      <= pwdata[DIM_W-1:0];
        REG_HEIGHT:    frame_height    <= pwdata[DIM_W-1:0];
        default:       ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD: prdata = CFG_DATA_W'(count_threshold);
      REG_WIDTH:     prdata = CFG_DATA_W'(line_width);
      REG_HEIGHT:    prdata = CFG_DATA_W'(frame_height);
      default:       prdata = '0;
    endcase
  end

  // clamped frame geometry
  logic [WCW-1:0] lw_ext;
  logic [HCW-1:0] fh_ext;
  logic [XW:0]    w_eff;
  logic [YW:0]    h_eff;

  assign lw_ext = WCW'(line_width);
  assign fh_ext = HCW'(frame_height);

  always_comb begin
    if (lw_ext == '0) begin
      w_eff = (XW + 1)'(1);
    end else if (lw_ext > WCW'(MAX_WIDTH)) begin
      w_eff = (XW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext[XW:0];
    end
    if (fh_ext == '0) begin
      h_eff = (YW + 1)'(1);
    end else if (fh_ext > HCW'(MAX_HEIGHT)) begin
      h_eff = (YW + 1)'(MAX_HEIGHT);
    end else begin
      h_eff = fh_ext[YW:0];
    end
  end

  // input handshake, gated by room in the output buffer
  logic [FCW-1:0] fifo_count;
  logic [FCW:0]   pending;
  logic           s1_valid;
  logic           s2_valid;
  logic           accept;

  assign pending  = (FCW + 1)'(fifo_count) + (FCW + 1)'(s1_valid) + (FCW + 1)'(s2_valid);
  assign s_tready = (pending < (FCW + 1)'(OUT_DEPTH));
  assign accept   = s_tvalid & s_tready;

  // raster position of the next pixel
  logic [XW-1:0] col_pos;
  logic [YW-1:0] row_pos;
  logic [XW:0]   col_inc;
  logic [YW:0]   row_inc;

  assign col_inc = (XW + 1)'(col_pos) + (XW + 1)'(1);
  assign row_inc = (YW + 1)'(row_pos) + (YW + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (col_inc >= w_eff) begin
        col_pos <= '0;
        row_pos <= (row_inc >= h_eff) ? '0 : row_inc[YW-1:0];
      end else begin
        col_pos <= col_inc[XW-1:0];
      end
    end
  end

  // window placement of the incoming pixel
  meta_t meta_in;

  always_comb begin
    meta_in.px       = s_tdata[0];
    meta_in.first    = (col_pos == '0);
    meta_in.interior = ((YW + 1)'(row_pos) >= (YW + 1)'(SB)) &&
                       ((YW + 1)'(row_pos) < h_eff) &&
                       ((XW + 1)'(col_pos) >= (XW + 1)'(2 * RADIUS_X)) &&
                       ((XW + 1)'(col_pos) < w_eff);
    meta_in.last     = ((XW + 1)'(col_pos) == w_eff - (XW + 1)'(1)) &&
                       ((YW + 1)'(row_pos) == h_eff - (YW + 1)'(1));
    meta_in.cx       = COORD_W'(col_pos - XW'(RADIUS_X));
    meta_in.cy       = COORD_W'(row_pos - YW'(RADIUS_Y));
  end

  // stage 1: line store read in flight
  meta_t         s1_meta;
  logic [XW-1:0] s1_x;
  logic          byp;
  logic [SB-1:0] byp_data;
  logic [SB-1:0] rd_data;
  logic [SB-1:0] old_col;
  logic [SB-1:0] new_col;
  logic [CSW-1:0] colsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // pixel in the write stage for the same column is forwarded
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta  <= meta_in;
      s1_x     <= col_pos;
      byp      <= s1_valid && (s1_x == col_pos);
      byp_data <= new_col;
    end
  end

  bbtf_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (SB),
    .ADDR_W (XW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_x),
    .wr_data (new_col)
  );

  // column sum over the stored rows plus the new pixel
  always_comb begin
    old_col = byp ? byp_data : rd_data;
    colsum  = CSW'(s1_meta.px);
    for (int i = 0; i < SB; i++) begin
      colsum = colsum + CSW'(old_col[i]);
    end
  end

  if (SB > 1) begin : g_shift
    assign new_col = {old_col[SB-2:0], s1_meta.px};
  end else begin : g_single
    assign new_col = s1_meta.px;
  end

  // row of column cells, newest sum in cell zero
  logic [CSW-1:0] cell_q [NC];

  for (genvar c = 0; c < NC; c++) begin : g_cell
    if (c == 0) begin : g_head
      bbtf_col_cell #(.W(CSW)) u_cell (
        .clk (clk),
        .rst (rst),
        .en  (s1_valid),
        .clr (1'b0),
        .d   (colsum),
        .q   (cell_q[c])
      );
    end else begin : g_body
      bbtf_col_cell #(.W(CSW)) u_cell (
        .clk (clk),
        .rst (rst),
        .en  (s1_valid),
        .clr (s1_meta.first),
        .d   (cell_q[c-1]),
        .q   (cell_q[c])
      );
    end
  end

  // running window count, restarted at the start of each row
  logic [WW-1:0] window_count;
  logic [WW-1:0] window_count_next;

  assign window_count_next = s1_meta.first ? WW'(colsum) :
                             window_count + WW'(colsum) - WW'(cell_q[NC-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
    end else if (s1_valid) begin
      window_count <= window_count_next;
    end
  end

  // stage 2: threshold compare into the output buffer
  meta_t   s2_meta;
  result_t res;
  result_t out_res;
  logic    push;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_meta <= s1_meta;
    end
  end

  assign push           = s2_valid & s2_meta.interior;
  assign res.pixel_out  = (CMPW'(window_count) >= CMPW'(count_threshold));
  assign res.center_x   = s2_meta.cx;
  assign res.center_y   = s2_meta.cy;
  assign res.frame_last = s2_meta.last;

  bbtf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res),
    .count     (fifo_count)
  );

  assign m_tdata = {3'b000, out_res.center_y, out_res.center_x, out_res.pixel_out};
  assign m_tlast = out_res.frame_last;

endmodule
